// File: sv/t2wd_pkg.sv
// Shared types and constants of the Type2 charstring width detector.
// No dependencies; every other file of the block refers to this package.
package t2wd_pkg;

  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned WIDTH_W    = 16;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_NOMINAL = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT = 8'd1;

  // Byte codes of the charstring grammar.
  localparam logic [7:0] OP_HSTEM     = 8'd1;
  localparam logic [7:0] OP_VSTEM     = 8'd3;
  localparam logic [7:0] OP_VMOVETO   = 8'd4;
  localparam logic [7:0] OP_ENDCHAR   = 8'd14;
  localparam logic [7:0] OP_HSTEMHM   = 8'd18;
  localparam logic [7:0] OP_HINTMASK  = 8'd19;
  localparam logic [7:0] OP_CNTRMASK  = 8'd20;
  localparam logic [7:0] OP_RMOVETO   = 8'd21;
  localparam logic [7:0] OP_HMOVETO   = 8'd22;
  localparam logic [7:0] OP_VSTEMHM   = 8'd23;
  localparam logic [7:0] LEAD_SHORT   = 8'd28;
  localparam logic [7:0] LEAD_MIN_NUM = 8'd32;
  localparam logic [7:0] LEAD_POS2    = 8'd247;
  localparam logic [7:0] LEAD_NEG2    = 8'd251;
  localparam logic [7:0] LEAD_FIXED   = 8'd255;
  localparam logic [15:0] BIAS_ONE    = 16'd139;
  localparam logic [15:0] BIAS_TWO    = 16'd108;

  typedef enum logic [1:0] {
    PH_SCAN    = 2'd0,
    PH_OPERAND = 2'd1,
    PH_SKIP    = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    OC_WIDTH_OP = 2'd0,
    OC_OTHER_OP = 2'd1,
    OC_NO_OP    = 2'd2,
    OC_TRUNC    = 2'd3
  } outcome_e;

  // One decision made by the front end, waiting to be turned into a result.
  typedef struct packed {
    logic               found;
    outcome_e           outcome;
    logic [WIDTH_W-1:0] first;
  } event_t;

endpackage

// File: sv/t2wd_front.sv
// Front end: parses charstring bytes and issues one decision per charstring.
// Depends on t2wd_pkg.
module t2wd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        data_byte_i,
  input  logic              last_byte_i,
  output logic              ev_valid_o,
  output t2wd_pkg::event_t  ev_o
);

  t2wd_pkg::phase_e phase_q, phase_d;
  logic [7:0]  lead_q, lead_d;
  logic [31:0] pend_q, pend_d;
  logic [2:0]  need_q, need_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        odd_q, odd_d;
  logic [15:0] first_q, first_d;

  logic [31:0] pend_n;
  logic [2:0]  need_n;
  logic [1:0]  lead_ofs;
  logic [15:0] op_val;
  logic [15:0] one_val;
  logic [15:0] two_mag;
  logic [2:0]  lead_need;
  logic        is_num;
  logic        bearing;
  logic        found;
  logic        count_en;
  logic [15:0] count_val;
  logic        do_clear;

  // Value of a multi-byte operand finished by the current byte.
  always_comb begin
    pend_n   = {pend_q[23:0], data_byte_i};
    need_n   = (need_q != 3'd0) ? need_q - 3'd1 : 3'd0;
    // Lead bytes 247 and 251 both end in 2'b11, so adding one gives the
    // offset from the first lead byte of either range.
    lead_ofs = lead_q[1:0] + 2'd1;
    two_mag  = {6'd0, lead_ofs, data_byte_i} + t2wd_pkg::BIAS_TWO;
    op_val   = pend_n[31:16];
    if (lead_q == t2wd_pkg::LEAD_SHORT) begin
      op_val = pend_n[15:0];
    end else if (lead_q < t2wd_pkg::LEAD_NEG2) begin
      op_val = two_mag;
    end else if (lead_q != t2wd_pkg::LEAD_FIXED) begin
      op_val = 16'd0 - two_mag;
    end else if (pend_n[31] && (pend_n[15:0] != 16'd0)) begin
      // Negative fixed value with a fraction rounds up toward zero.
      op_val = pend_n[31:16] + 16'd1;
    end
  end

  always_comb begin
    one_val = {8'd0, data_byte_i} - t2wd_pkg::BIAS_ONE;
    is_num  = (data_byte_i >= t2wd_pkg::LEAD_MIN_NUM) ||
              (data_byte_i == t2wd_pkg::LEAD_SHORT);
    if (data_byte_i == t2wd_pkg::LEAD_SHORT) begin
      lead_need = 3'd2;
    end else if (data_byte_i == t2wd_pkg::LEAD_FIXED) begin
      lead_need = 3'd4;
    end else if (data_byte_i >= t2wd_pkg::LEAD_POS2) begin
      lead_need = 3'd1;
    end else begin
      lead_need = 3'd0;
    end
  end

  always_comb begin
    bearing = 1'b1;
    case (data_byte_i)
      t2wd_pkg::OP_HSTEM, t2wd_pkg::OP_VSTEM, t2wd_pkg::OP_HSTEMHM,
      t2wd_pkg::OP_VSTEMHM, t2wd_pkg::OP_HINTMASK, t2wd_pkg::OP_CNTRMASK,
      t2wd_pkg::OP_ENDCHAR: found = odd_q;
      t2wd_pkg::OP_RMOVETO: found = (cnt_q > 2'd2);
      t2wd_pkg::OP_HMOVETO, t2wd_pkg::OP_VMOVETO: found = (cnt_q > 2'd1);
      default: begin
        found   = 1'b0;
        bearing = 1'b0;
      end
    endcase
  end

  // Next state of the scan.
  always_comb begin
    phase_d   = phase_q;
    lead_d    = lead_q;
    pend_d    = pend_q;
    need_d    = need_q;
    cnt_d     = cnt_q;
    odd_d     = odd_q;
    first_d   = first_q;
    count_en  = 1'b0;
    count_val = one_val;
    do_clear  = 1'b0;
    if (accept_i) begin
      case (phase_q)
        t2wd_pkg::PH_SKIP: begin
          do_clear = last_byte_i;
        end
        t2wd_pkg::PH_OPERAND: begin
          pend_d = pend_n;
          need_d = need_n;
          if (need_n == 3'd0) begin
            count_en  = 1'b1;
            count_val = op_val;
            phase_d   = t2wd_pkg::PH_SCAN;
          end
          do_clear = last_byte_i;
        end
        default: begin
          if (is_num) begin
            if (lead_need == 3'd0) begin
              count_en = 1'b1;
            end else begin
              lead_d  = data_byte_i;
              pend_d  = 32'd0;
              need_d  = lead_need;
              phase_d = t2wd_pkg::PH_OPERAND;
            end
          end else begin
            phase_d = t2wd_pkg::PH_SKIP;
          end
          do_clear = last_byte_i;
        end
      endcase
    end
    if (count_en) begin
      if (cnt_q == 2'd0) begin
        first_d = count_val;
      end
      if (cnt_q != 2'd3) begin
        cnt_d = cnt_q + 2'd1;
      end
      odd_d = ~odd_q;
    end
    if (do_clear) begin
      phase_d = t2wd_pkg::PH_SCAN;
      lead_d  = 8'd0;
      pend_d  = 32'd0;
      need_d  = 3'd0;
      cnt_d   = 2'd0;
      odd_d   = 1'b0;
      first_d = 16'd0;
    end
  end

  // Decision issued by the current byte, if any.
  always_comb begin
    ev_valid_o   = 1'b0;
    ev_o.found   = 1'b0;
    ev_o.outcome = t2wd_pkg::OC_NO_OP;
    ev_o.first   = first_q;
    if (accept_i) begin
      case (phase_q)
        t2wd_pkg::PH_SKIP: begin
          ev_valid_o = 1'b0;
        end
        t2wd_pkg::PH_OPERAND: begin
          ev_valid_o = last_byte_i;
          if (need_n != 3'd0) begin
            ev_o.outcome = t2wd_pkg::OC_TRUNC;
          end
        end
        default: begin
          if (is_num) begin
            ev_valid_o = last_byte_i;
            if (lead_need != 3'd0) begin
              ev_o.outcome = t2wd_pkg::OC_TRUNC;
            end
          end else begin
            ev_valid_o   = 1'b1;
            ev_o.found   = found;
            ev_o.outcome = bearing ? t2wd_pkg::OC_WIDTH_OP : t2wd_pkg::OC_OTHER_OP;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= t2wd_pkg::PH_SCAN;
      lead_q  <= 8'd0;
      pend_q  <= 32'd0;
      need_q  <= 3'd0;
      cnt_q   <= 2'd0;
      odd_q   <= 1'b0;
      first_q <= 16'd0;
    end else begin
      phase_q <= phase_d;
      lead_q  <= lead_d;
      pend_q  <= pend_d;
      need_q  <= need_d;
      cnt_q   <= cnt_d;
      odd_q   <= odd_d;
      first_q <= first_d;
    end
  end

endmodule

// File: sv/t2wd_fifo.sv
// Short decision queue between the front end and the back end.
// Depends on t2wd_pkg.
module t2wd_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_i,
  input  t2wd_pkg::event_t  wdata_i,
  input  logic              rd_i,
  output t2wd_pkg::event_t  rdata_o,
  output logic              full_o,
  output logic              empty_o
);

  t2wd_pkg::event_t mem_q [t2wd_pkg::FIFO_DEPTH];
  logic [t2wd_pkg::FIFO_PTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [t2wd_pkg::FIFO_CNT_W-1:0] cnt_q, cnt_d;
  logic do_wr, do_rd;

  assign full_o  = (cnt_q == t2wd_pkg::FIFO_CNT_W'(t2wd_pkg::FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = do_wr ? wptr_q + t2wd_pkg::FIFO_PTR_W'(1) : wptr_q;
    rptr_d = do_rd ? rptr_q + t2wd_pkg::FIFO_PTR_W'(1) : rptr_q;
    cnt_d  = cnt_q;
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + t2wd_pkg::FIFO_CNT_W'(1);
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - t2wd_pkg::FIFO_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// File: sv/t2wd_back.sv
// Back end: holds the width registers and turns decisions into results.
// Depends on t2wd_pkg.
module t2wd_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [t2wd_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]                    cfg_data_i,
  input  logic                           ev_avail_i,
  input  t2wd_pkg::event_t               ev_i,
  output logic                           ev_take_o,
  input  logic                           pop_i,
  output logic                           out_valid_o,
  output logic [15:0]                    advance_o,
  output logic                           width_found_o,
  output logic [1:0]                     outcome_o
);

  logic [15:0] nominal_q, default_q;
  logic        valid_q, valid_d;
  logic [15:0] adv_q, adv_d;
  logic        found_q;
  t2wd_pkg::outcome_e outc_q;

  // A new result loads when the output stage is free or being emptied.
  assign ev_take_o = ev_avail_i && (!valid_q || pop_i);
  assign adv_d     = ev_i.found ? nominal_q + ev_i.first : default_q;

  always_comb begin
    valid_d = valid_q;
    if (ev_take_o) begin
      valid_d = 1'b1;
    end else if (pop_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nominal_q <= 16'd0;
      default_q <= 16'd0;
      valid_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (cfg_we_i && (cfg_index_i == t2wd_pkg::CFG_NOMINAL)) begin
        nominal_q <= cfg_data_i;
      end
      if (cfg_we_i && (cfg_index_i == t2wd_pkg::CFG_DEFAULT)) begin
        default_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ev_take_o) begin
      adv_q   <= adv_d;
      found_q <= ev_i.found;
      outc_q  <= ev_i.outcome;
    end
  end

  assign out_valid_o   = valid_q;
  assign advance_o     = adv_q;
  assign width_found_o = found_q;
  assign outcome_o     = outc_q;

endmodule

// File: sv/type2_charstring_width_detect.sv
// Top level of the Type2 charstring advance-width detector.
// Depends on t2wd_pkg, t2wd_front, t2wd_fifo and t2wd_back.
//
// Charstring bytes enter on a queue-style write side: a beat is taken at a
// rising edge with push high and full low; data_byte_i carries the byte and
// last_byte_i marks the final byte of a charstring. One beat per cycle is
// sustained while full is low. While empty is low the oldest result sits on
// advance_o, width_found_o and outcome_o; it is taken at a rising edge with
// pop high. Each charstring gives one result, at its first operator byte or
// at its final byte, whichever comes first; bytes after the decision are
// dropped. A four-entry decision queue and a one-entry output register
// decouple the parser from the reader: a stalled reader fills both before
// full rises, and full has no combinational path from pop. Width registers
// are written through cfg_valid_i/cfg_ready_o; the user must write them
// only while the block is idle, which the block itself does not enforce:
// cfg_ready_o is always high. Index 0 is the nominal width, index 1 the
// default width; other indexes are ignored. Reset clears the parser, the
// queue, the output register and both width registers.
module type2_charstring_width_detect (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  output logic                           full,
  input  logic [7:0]                     data_byte_i,
  input  logic                           last_byte_i,
  output logic                           empty,
  input  logic                           pop,
  output logic [15:0]                    advance_o,
  output logic                           width_found_o,
  output logic [1:0]                     outcome_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [t2wd_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]                    cfg_data_i
);

  logic             in_accept;
  logic             ev_valid;
  t2wd_pkg::event_t ev_front;
  t2wd_pkg::event_t ev_queue;
  logic             q_full;
  logic             q_empty;
  logic             q_take;
  logic             out_valid;

  // The queue must have a free entry before a byte is taken, since any byte
  // may turn out to be the deciding one.
  assign full        = q_full;
  assign in_accept   = push && !q_full;
  assign cfg_ready_o = 1'b1;
  assign empty       = !out_valid;

  t2wd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_accept),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .ev_valid_o  (ev_valid),
    .ev_o        (ev_front)
  );

  t2wd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (ev_valid),
    .wdata_i (ev_front),
    .rd_i    (q_take),
    .rdata_o (ev_queue),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  t2wd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .ev_avail_i    (!q_empty),
    .ev_i          (ev_queue),
    .ev_take_o     (q_take),
    .pop_i         (pop),
    .out_valid_o   (out_valid),
    .advance_o     (advance_o),
    .width_found_o (width_found_o),
    .outcome_o     (outcome_o)
  );

endmodule

// File: sv/t2wd_checker.sv
// Port-level checks of the width detector, bound to the top level.
// Depends on t2wd_pkg for the outcome codes and the index width.
module t2wd_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           push,
  input logic                           full,
  input logic [7:0]                     data_byte_i,
  input logic                           last_byte_i,
  input logic                           empty,
  input logic                           pop,
  input logic [15:0]                    advance_o,
  input logic                           width_found_o,
  input logic [1:0]                     outcome_o,
  input logic                           cfg_valid_i,
  input logic                           cfg_ready_o,
  input logic [t2wd_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input logic [15:0]                    cfg_data_i
);

  // A held result stays on the ports until it is popped.
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> !empty)
    else $error("result withdrawn before pop");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> ($stable(advance_o) && $stable(width_found_o) &&
                          $stable(outcome_o)))
    else $error("result changed while stalled");

  // Only a width-bearing operator can report an explicit width.
  a_found_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && width_found_o) |-> (outcome_o == t2wd_pkg::OC_WIDTH_OP))
    else $error("width found with a non width-bearing outcome");

  // No result can be present during reset or in the cycle after it.
  a_reset_empty: assert property (@(posedge clk_i)
    (!rst_ni || $past(!rst_ni)) |-> empty)
    else $error("result present right after reset");

endmodule

bind type2_charstring_width_detect t2wd_checker u_t2wd_checker (.*);

// File: sim/type2_charstring_width_detect_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the Type2 charstring advance-width detector.
// Depends on t2wd_pkg and on type2_charstring_width_detect with its submodules.
// A built-in predictor tracks every byte beat and checks each result beat.

module type2_charstring_width_detect_tb;

  // The random part stops once this many byte beats have been sent in it.
  localparam int unsigned ITEM_GOAL     = 1560;
  localparam int unsigned PHASES        = 8;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned HOLD_CYCLES   = 120;
  localparam int unsigned STUCK_LIMIT   = 3000;
  localparam int unsigned IDLE_PCT      = 10;

  localparam logic [7:0] OP_ESCAPE = 8'd12;
  localparam logic [7:0] OP_LAST   = 8'd31;
  localparam logic [t2wd_pkg::CFG_IDX_W-1:0] CFG_FIRST_UNUSED =
    t2wd_pkg::CFG_DEFAULT + t2wd_pkg::CFG_IDX_W'(1);
  localparam logic [t2wd_pkg::CFG_IDX_W-1:0] CFG_TOP_INDEX = '1;

  typedef struct packed {
    logic [15:0]        advance;
    logic               found;
    t2wd_pkg::outcome_e outcome;
  } width_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  logic [7:0] data_byte = 8'h00;
  logic last_byte = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic [15:0] advance;
  logic width_found;
  logic [1:0] outcome;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [t2wd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0] cfg_data = 16'h0000;

  type2_charstring_width_detect uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .data_byte_i   (data_byte),
    .last_byte_i   (last_byte),
    .empty         (empty),
    .pop           (pop),
    .advance_o     (advance),
    .width_found_o (width_found),
    .outcome_o     (outcome),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  always #5 clk_i = ~clk_i;

  // Predictor state: the two width registers and the charstring scan.
  logic [15:0]      nominal_q = 16'h0000;
  logic [15:0]      default_q = 16'h0000;
  t2wd_pkg::phase_e cs_phase = t2wd_pkg::PH_SCAN;
  logic [7:0]       cs_lead = 8'h00;
  logic [31:0]      cs_pending = 32'h0;
  logic [2:0]       cs_need = 3'd0;
  logic [1:0]       cs_count = 2'd0;
  logic             cs_odd = 1'b0;
  logic [15:0]      cs_first = 16'h0000;

  width_result_t expected_widths[$];
  logic [7:0]    cs_buf[$];
  int unsigned   sent_bytes = 0;
  int unsigned   failures = 0;
  int unsigned   stuck_cycles = 0;
  int unsigned   hold_left = 0;
  logic          hold_request = 1'b0;
  bit            gaps_on = 1'b1;
  bit            stalls_on = 1'b1;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void clear_charstring();
    cs_phase   = t2wd_pkg::PH_SCAN;
    cs_lead    = 8'h00;
    cs_pending = 32'h0;
    cs_need    = 3'd0;
    cs_count   = 2'd0;
    cs_odd     = 1'b0;
    cs_first   = 16'h0000;
  endfunction

  // Integer value of a finished operand as a 16-bit pattern. A 16.16 fixed
  // operand keeps its integer part, truncated toward zero.
  function automatic logic [15:0] operand_value(input logic [7:0] lead,
                                                input logic [31:0] extra);
    logic [31:0] mag;
    if (lead == t2wd_pkg::LEAD_SHORT) return extra[15:0];
    if (lead < t2wd_pkg::LEAD_POS2) return {8'h00, lead} - t2wd_pkg::BIAS_ONE;
    if (lead < t2wd_pkg::LEAD_NEG2) begin
      return {lead - t2wd_pkg::LEAD_POS2, extra[7:0]} + t2wd_pkg::BIAS_TWO;
    end
    if (lead < t2wd_pkg::LEAD_FIXED) begin
      return 16'h0000 - ({lead - t2wd_pkg::LEAD_NEG2, extra[7:0]} + t2wd_pkg::BIAS_TWO);
    end
    if (extra[31]) begin
      mag = ~extra + 32'd1;
      return 16'h0000 - mag[31:16];
    end
    return extra[31:16];
  endfunction

  // The count saturates at three, which is all any operator rule looks at.
  function automatic void count_operand(input logic [15:0] value);
    if (cs_count == 2'd0) cs_first = value;
    if (cs_count != 2'd3) cs_count = cs_count + 2'd1;
    cs_odd = ~cs_odd;
  endfunction

  function automatic void expect_width(input logic found, input t2wd_pkg::outcome_e oc);
    width_result_t r;
    r.advance = found ? nominal_q + cs_first : default_q;
    r.found   = found;
    r.outcome = oc;
    expected_widths = {expected_widths, r};
  endfunction

  // Advances the scan by one accepted byte beat and queues its result, if any.
  function automatic void predict_byte(input logic [7:0] b, input logic last);
    logic [2:0] need;
    logic       found;
    logic       bearing;
    sent_bytes++;
    case (cs_phase)
      t2wd_pkg::PH_SKIP: begin
        if (last) clear_charstring();
      end
      t2wd_pkg::PH_OPERAND: begin
        cs_pending = {cs_pending[23:0], b};
        if (cs_need != 3'd0) cs_need = cs_need - 3'd1;
        if (cs_need == 3'd0) begin
          count_operand(operand_value(cs_lead, cs_pending));
          cs_phase = t2wd_pkg::PH_SCAN;
          if (last) begin
            expect_width(1'b0, t2wd_pkg::OC_NO_OP);
            clear_charstring();
          end
        end else if (last) begin
          expect_width(1'b0, t2wd_pkg::OC_TRUNC);
          clear_charstring();
        end
      end
      default: begin
        if (b >= t2wd_pkg::LEAD_MIN_NUM || b == t2wd_pkg::LEAD_SHORT) begin
          need = 3'd0;
          if (b == t2wd_pkg::LEAD_SHORT) need = 3'd2;
          else if (b == t2wd_pkg::LEAD_FIXED) need = 3'd4;
          else if (b >= t2wd_pkg::LEAD_POS2) need = 3'd1;
          if (need == 3'd0) begin
            count_operand(operand_value(b, 32'h0));
            if (last) begin
              expect_width(1'b0, t2wd_pkg::OC_NO_OP);
              clear_charstring();
            end
          end else begin
            cs_lead    = b;
            cs_pending = 32'h0;
            cs_need    = need;
            cs_phase   = t2wd_pkg::PH_OPERAND;
            if (last) begin
              expect_width(1'b0, t2wd_pkg::OC_TRUNC);
              clear_charstring();
            end
          end
        end else begin
          // An operator byte decides the charstring.
          bearing = 1'b1;
          found   = 1'b0;
          case (b)
            t2wd_pkg::OP_HSTEM, t2wd_pkg::OP_VSTEM, t2wd_pkg::OP_HSTEMHM,
            t2wd_pkg::OP_VSTEMHM, t2wd_pkg::OP_HINTMASK, t2wd_pkg::OP_CNTRMASK,
            t2wd_pkg::OP_ENDCHAR: found = cs_odd;
            t2wd_pkg::OP_RMOVETO: found = (cs_count > 2'd2);
            t2wd_pkg::OP_HMOVETO, t2wd_pkg::OP_VMOVETO: found = (cs_count > 2'd1);
            default: bearing = 1'b0;
          endcase
          expect_width(found, bearing ? t2wd_pkg::OC_WIDTH_OP : t2wd_pkg::OC_OTHER_OP);
          if (last) clear_charstring();
          else cs_phase = t2wd_pkg::PH_SKIP;
        end
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: pop with random stalls and an occasional long hold-off, and
  // compare every result beat with the oldest expectation.
  // ---------------------------------------------------------------------------

  always @(negedge clk_i) begin
    if (hold_request) begin
      hold_request <= 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      pop <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      pop <= !(stalls_on && $urandom_range(0, 99) < IDLE_PCT);
    end
  end

  always @(posedge clk_i) begin : check_results
    width_result_t want;
    if (rst_ni && pop && !empty) begin
      if (expected_widths.size() == 0) begin
        $error("result beat with nothing expected: advance %h", advance);
        failures++;
      end else begin
        want = expected_widths.pop_front();
        if (advance !== want.advance) begin
          $error("advance: expected %h, got %h", want.advance, advance);
          failures++;
        end
        if (width_found !== want.found) begin
          $error("width_found: expected %b, got %b", want.found, width_found);
          failures++;
        end
        if (outcome !== want.outcome) begin
          $error("outcome: expected %0d, got %0d", want.outcome, outcome);
          failures++;
        end
      end
    end
  end

  // Any accepted beat on any channel counts as progress.
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
  end

  initial begin
    wait (stuck_cycles >= STUCK_LIMIT);
    $display("FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Byte side and register writes. Every task starts and ends at a falling
  // edge, so push stays high from one beat to the next without a glitch.
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] rand_between(input int unsigned lo, input int unsigned hi);
    return 8'($urandom_range(lo, hi));
  endfunction

  function automatic logic [7:0] rand_byte();
    return rand_between(0, 255);
  endfunction

  function automatic void add_byte(input logic [7:0] b);
    cs_buf = {cs_buf, b};
  endfunction

  // A gap starts at half the idle percentage to allow for its random length.
  task automatic push_byte(input logic [7:0] b, input logic last);
    if (gaps_on && $urandom_range(0, 99) < IDLE_PCT / 2) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    push      <= 1'b1;
    data_byte <= b;
    last_byte <= last;
    do @(posedge clk_i); while (full);
    predict_byte(b, last);
    @(negedge clk_i);
  endtask

  task automatic send_charstring();
    int n;
    n = cs_buf.size();
    for (int i = 0; i < n; i++) push_byte(cs_buf[i], i == n - 1);
    cs_buf.delete();
  endtask

  // Stops sending, waits for every expected result, then lets the pipeline
  // settle in case a byte that made no result is still in flight.
  task automatic wait_drained();
    push <= 1'b0;
    while (expected_widths.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_config(input logic [t2wd_pkg::CFG_IDX_W-1:0] idx,
                              input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready);
    if (idx == t2wd_pkg::CFG_NOMINAL) nominal_q = value;
    else if (idx == t2wd_pkg::CFG_DEFAULT) default_q = value;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_widths(input logic [15:0] nominal, input logic [15:0] dflt);
    write_config(t2wd_pkg::CFG_NOMINAL, nominal);
    write_config(t2wd_pkg::CFG_DEFAULT, dflt);
  endtask

  // ---------------------------------------------------------------------------
  // Charstring generators
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] pick_bearing_op();
    case ($urandom_range(0, 9))
      0: return t2wd_pkg::OP_HSTEM;
      1: return t2wd_pkg::OP_VSTEM;
      2: return t2wd_pkg::OP_HSTEMHM;
      3: return t2wd_pkg::OP_VSTEMHM;
      4: return t2wd_pkg::OP_HINTMASK;
      5: return t2wd_pkg::OP_CNTRMASK;
      6: return t2wd_pkg::OP_ENDCHAR;
      7: return t2wd_pkg::OP_RMOVETO;
      8: return t2wd_pkg::OP_HMOVETO;
      default: return t2wd_pkg::OP_VMOVETO;
    endcase
  endfunction

  function automatic logic [7:0] pick_any_op();
    logic [7:0] b;
    do b = rand_between(0, OP_LAST); while (b == t2wd_pkg::LEAD_SHORT);
    return b;
  endfunction

  task automatic add_operand();
    case ($urandom_range(0, 4))
      0: add_byte(rand_between(t2wd_pkg::LEAD_MIN_NUM, t2wd_pkg::LEAD_POS2 - 1));
      1: begin
        add_byte(rand_between(t2wd_pkg::LEAD_POS2, t2wd_pkg::LEAD_NEG2 - 1));
        add_byte(rand_byte());
      end
      2: begin
        add_byte(rand_between(t2wd_pkg::LEAD_NEG2, t2wd_pkg::LEAD_FIXED - 1));
        add_byte(rand_byte());
      end
      3: begin
        add_byte(t2wd_pkg::LEAD_SHORT);
        repeat (2) add_byte(rand_byte());
      end
      default: begin
        add_byte(t2wd_pkg::LEAD_FIXED);
        repeat (4) add_byte(rand_byte());
      end
    endcase
  endtask

  // A multi-byte operand cut short by the end of the charstring.
  task automatic add_partial_operand();
    case ($urandom_range(0, 2))
      0: begin
        add_byte(t2wd_pkg::LEAD_SHORT);
        repeat ($urandom_range(0, 1)) add_byte(rand_byte());
      end
      1: begin
        add_byte(t2wd_pkg::LEAD_FIXED);
        repeat ($urandom_range(0, 3)) add_byte(rand_byte());
      end
      default: add_byte(rand_between(t2wd_pkg::LEAD_POS2, t2wd_pkg::LEAD_FIXED - 1));
    endcase
  endtask

  // Mostly well-formed charstrings with random operands; the rest end with
  // no operator, end inside an operand, or are plain noise.
  task automatic random_charstring();
    int unsigned kind;
    kind = $urandom_range(0, 99);
    repeat ($urandom_range(0, 5)) add_operand();
    if (kind < 80) begin
      add_byte(kind < 68 ? pick_bearing_op() : pick_any_op());
      repeat ($urandom_range(0, 3)) add_byte(rand_byte());
    end else if (kind < 90) begin
      if (cs_buf.size() == 0) add_operand();
    end else if (kind < 95) begin
      add_partial_operand();
    end else begin
      cs_buf.delete();
      repeat ($urandom_range(1, 6)) add_byte(rand_byte());
    end
    send_charstring();
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // An unused index must leave both widths alone.
  task automatic test_register_access();
    write_config(CFG_FIRST_UNUSED, 16'hBEEF);
    set_widths(16'd100, 16'hFFFB);
  endtask

  // Charstrings covering every operand form, decided by width-bearing operators.
  task automatic test_operand_forms();
    cs_buf = '{t2wd_pkg::LEAD_MIN_NUM, t2wd_pkg::OP_HSTEM};
    send_charstring();
    // Negative 16.16 value just above -32768 by a fraction: truncates toward zero.
    cs_buf = '{t2wd_pkg::LEAD_FIXED, 8'h80, 8'h00, 8'h00, 8'h01, t2wd_pkg::OP_ENDCHAR};
    send_charstring();
    // Most negative shortint as the width.
    cs_buf = '{t2wd_pkg::LEAD_SHORT, 8'h80, 8'h00, t2wd_pkg::LEAD_POS2 - 8'd1,
               t2wd_pkg::LEAD_NEG2 - 8'd1, 8'hFF, t2wd_pkg::OP_RMOVETO};
    send_charstring();
    // Trailing bytes after the decision are skipped, including the final one.
    cs_buf = '{t2wd_pkg::LEAD_POS2, 8'h00, t2wd_pkg::LEAD_FIXED - 8'd1, 8'hFF,
               t2wd_pkg::OP_HMOVETO, 8'hFF, 8'h00};
    send_charstring();
  endtask

  task automatic test_outcomes();
    cs_buf = '{t2wd_pkg::LEAD_NEG2, 8'h00, t2wd_pkg::OP_VMOVETO};  // too few operands
    send_charstring();
    cs_buf = '{OP_ESCAPE, OP_ESCAPE};          // escape is an other operator
    send_charstring();
    cs_buf = '{t2wd_pkg::BIAS_ONE[7:0]};       // ends with no operator
    send_charstring();
    cs_buf = '{t2wd_pkg::LEAD_FIXED, 8'h12};   // ends inside an operand
    send_charstring();
    cs_buf = '{t2wd_pkg::OP_HINTMASK};         // decision on the final byte
    send_charstring();
  endtask

  // A width register written in the middle of a charstring applies to its
  // result.
  task automatic test_live_register_write();
    push_byte(t2wd_pkg::LEAD_MIN_NUM + 8'd108, 1'b0);
    wait_drained();
    write_config(t2wd_pkg::CFG_NOMINAL, 16'h7FFF);
    push_byte(t2wd_pkg::OP_VSTEM, 1'b1);
    wait_drained();
  endtask

  // The reader holds off for a long stretch while the sender keeps going, so
  // the block fills up and raises full. Then the sender waits for all results.
  task automatic test_backpressure();
    hold_request <= 1'b1;
    repeat (24) begin
      add_byte(rand_between(t2wd_pkg::LEAD_MIN_NUM, t2wd_pkg::LEAD_POS2 - 1));
      add_byte(pick_bearing_op());
      send_charstring();
    end
    wait_drained();
  endtask

  // Random charstrings over several width settings, extremes first. One
  // phase runs with no idling on either side.
  task automatic test_random_charstrings();
    int unsigned target;
    for (int k = 0; k < PHASES; k++) begin
      wait_drained();
      write_config(t2wd_pkg::CFG_IDX_W'($urandom_range(CFG_FIRST_UNUSED, CFG_TOP_INDEX)),
                   16'($urandom_range(0, 65535)));
      case (k)
        0: set_widths(16'h0000, 16'h0000);
        1: set_widths(16'h7FFF, 16'h8000);
        2: set_widths(16'h8000, 16'h7FFF);
        3: set_widths(16'hFFFF, 16'h0001);
        default: set_widths(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
      endcase
      gaps_on   = (k != 2);
      stalls_on = (k != 2);
      target = sent_bytes + ITEM_GOAL / PHASES;
      while (sent_bytes < target) random_charstring();
    end
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
  endtask

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_register_access();
    test_operand_forms();
    test_outcomes();
    test_live_register_write();
    test_backpressure();
    test_random_charstrings();
    wait_drained();
    repeat (8) @(negedge clk_i);
    if (failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
